// ===== sv/gregorian_date_arith_assert.svh =====
`ifndef GREGORIAN_DATE_ARITH_ASSERT_SVH
`define GREGORIAN_DATE_ARITH_ASSERT_SVH
// Assertion helpers clocked on aclk; GDA_ASSERT is disabled during reset, GDA_ASSERT_RST is not.
`define GDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define GDA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`endif

// ===== sv/gda_pkg.sv =====
package gda_pkg;

    localparam int unsigned YearMax = 9999;

    // Input fields, unpacked from s_axis_tdata.
    typedef struct packed {
        logic [15:0] days_to_add;
        logic [13:0] b_year;
        logic [3:0]  b_month;
        logic [4:0]  b_day;
        logic [13:0] a_year;
        logic [3:0]  a_month;
        logic [4:0]  a_day;
    } item_t;

    // Front-to-back job: classified item.
    typedef struct packed {
        logic        invalid;
        logic [21:0] sa;
        logic [21:0] sb;
        logic [15:0] k;
    } job_t;

    typedef struct packed {
        logic [4:0]  sum_day;
        logic [3:0]  sum_month;
        logic [13:0] sum_year;
        logic        dates_equal;
        logic        a_later;
        logic [21:0] day_distance;
        logic        sum_overflow;
        logic        input_invalid;
    } res_t;

    typedef enum logic [2:0] {
        F_IDLE, F_YEARS, F_MONTHS_A, F_MONTHS_B, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_SUM, B_YEARS, B_MONTHS, B_DONE
    } back_state_t;

    // Century index y / 100 by reciprocal multiplication, exact for any 14-bit y.
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [13:0] r;
        prod = 27'(y) * 27'd5243;
        q = prod[26:19];
        r = y - 14'(q) * 14'd100;
        return (y[1:0] == 2'b00) && ((r != 14'd0) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] n;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            4'd2:                    n = is_leap(y) ? 5'd29 : 5'd28;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

    // Serial of 31/12/9999 with 1/1/1 as zero.
    localparam logic [21:0] LastSerial = 22'd3652058;

endpackage

// ===== sv/gda_front.sv =====
// Validate both dates and build their serial day numbers, one year block
// (400/100/4/1) or one month per cycle.
module gda_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  gda_pkg::item_t in_item,
    output logic          job_valid,
    input  logic          job_ready,
    output gda_pkg::job_t  job
);
    gda_pkg::front_state_t state_reg, state_next;
    gda_pkg::item_t        item_reg, item_next;
    logic [13:0] ya_reg, ya_next, yb_reg, yb_next;
    logic [21:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [3:0]  mi_reg, mi_next;
    logic        inv_reg, inv_next;

    logic va, vb;
    assign va = (item_reg.a_month >= 4'd1) && (item_reg.a_month <= 4'd12)
             && (item_reg.a_year >= 14'd1) && (item_reg.a_year <= 14'(gda_pkg::YearMax))
             && (item_reg.a_day >= 5'd1)
             && (item_reg.a_day <= gda_pkg::days_in(item_reg.a_month, item_reg.a_year));
    assign vb = (item_reg.b_month >= 4'd1) && (item_reg.b_month <= 4'd12)
             && (item_reg.b_year >= 14'd1) && (item_reg.b_year <= 14'(gda_pkg::YearMax))
             && (item_reg.b_day >= 5'd1)
             && (item_reg.b_day <= gda_pkg::days_in(item_reg.b_month, item_reg.b_year));

    // Count elapsed years, largest block that fits first.
    function automatic void year_step(input logic [13:0] y, input logic [21:0] s,
                                      output logic [13:0] yo, output logic [21:0] so);
        if (y >= 14'd400) begin
            yo = y - 14'd400; so = s + 22'd146097;
        end else if (y >= 14'd100) begin
            yo = y - 14'd100; so = s + 22'd36524;
        end else if (y >= 14'd4) begin
            yo = y - 14'd4; so = s + 22'd1461;
        end else begin
            yo = y - 14'd1; so = s + 22'd365;
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gda_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        item_reg <= item_next;
        ya_reg <= ya_next; yb_reg <= yb_next;
        sa_reg <= sa_next; sb_reg <= sb_next;
        mi_reg <= mi_next; inv_reg <= inv_next;
    end

    always_comb begin
        logic [13:0] yt;
        logic [21:0] st;
        state_next = state_reg;
        item_next = item_reg;
        ya_next = ya_reg; yb_next = yb_reg;
        sa_next = sa_reg; sb_next = sb_reg;
        mi_next = mi_reg; inv_next = inv_reg;
        in_ready = 1'b0;
        job_valid = 1'b0;
        yt = '0; st = '0;
        unique case (state_reg)
            gda_pkg::F_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next = in_item;
                    // Elapsed whole years are year minus one.
                    ya_next = in_item.a_year - 14'd1;
                    yb_next = in_item.b_year - 14'd1;
                    sa_next = '0; sb_next = '0;
                    state_next = gda_pkg::F_YEARS;
                end
            end
            gda_pkg::F_YEARS: begin
                inv_next = !(va && vb);
                if (!(va && vb)) begin
                    state_next = gda_pkg::F_PUSH;
                end else if (ya_reg == 14'd0 && yb_reg == 14'd0) begin
                    mi_next = 4'd1;
                    sa_next = sa_reg + 22'(item_reg.a_day) - 22'd1;
                    sb_next = sb_reg + 22'(item_reg.b_day) - 22'd1;
                    state_next = gda_pkg::F_MONTHS_A;
                end else begin
                    if (ya_reg != 14'd0) begin
                        year_step(ya_reg, sa_reg, yt, st);
                        ya_next = yt; sa_next = st;
                    end
                    if (yb_reg != 14'd0) begin
                        year_step(yb_reg, sb_reg, yt, st);
                        yb_next = yt; sb_next = st;
                    end
                end
            end
            gda_pkg::F_MONTHS_A: begin
                if (mi_reg >= item_reg.a_month) begin
                    mi_next = 4'd1;
                    state_next = gda_pkg::F_MONTHS_B;
                end else begin
                    sa_next = sa_reg + 22'(gda_pkg::days_in(mi_reg, item_reg.a_year));
                    mi_next = mi_reg + 4'd1;
                end
            end
            gda_pkg::F_MONTHS_B: begin
                if (mi_reg >= item_reg.b_month) begin
                    state_next = gda_pkg::F_PUSH;
                end else begin
                    sb_next = sb_reg + 22'(gda_pkg::days_in(mi_reg, item_reg.b_year));
                    mi_next = mi_reg + 4'd1;
                end
            end
            gda_pkg::F_PUSH: begin
                job_valid = 1'b1;
                if (job_ready) begin
                    state_next = gda_pkg::F_IDLE;
                end
            end
            default: state_next = gda_pkg::F_IDLE;
        endcase
    end

    assign job.invalid = inv_reg;
    assign job.sa = sa_reg;
    assign job.sb = sb_reg;
    assign job.k = item_reg.days_to_add;
endmodule

// ===== sv/gda_queue.sv =====
// Two-entry job queue between front and back.
module gda_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  gda_pkg::job_t  wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output gda_pkg::job_t  rd_job
);
    gda_pkg::job_t mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_job = mem_reg[rp_reg];

    always_comb begin
        wp_next = wp_reg ^ push;
        rp_next = rp_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= wr_job;
        end
    end
endmodule

// ===== sv/gda_back.sv =====
// Compare, take the distance, and turn A plus the count back into a date,
// one year block or one month per cycle.
module gda_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  gda_pkg::job_t  job,
    output logic          res_valid,
    input  logic          res_ready,
    output gda_pkg::res_t  res
);
    gda_pkg::back_state_t state_reg, state_next;
    gda_pkg::res_t res_reg, res_next;
    logic [21:0] s_reg, s_next;
    logic [13:0] y_reg, y_next;
    logic [3:0]  m_reg, m_next;
    logic [1:0]  c_reg, c_next;     // block count within a level
    logic [1:0]  lv_reg, lv_next;   // 0:400y 1:100y 2:4y 3:1y
    logic [21:0] sa_reg, sa_next;
    logic [15:0] k_reg, k_next;

    logic [21:0] blk;
    always_comb begin
        case (lv_reg)
            2'd0: blk = 22'd146097;
            2'd1: blk = 22'd36524;
            2'd2: blk = 22'd1461;
            default: blk = 22'd365;
        endcase
    end
    logic [13:0] blk_years;
    always_comb begin
        case (lv_reg)
            2'd0: blk_years = 14'd400;
            2'd1: blk_years = 14'd100;
            2'd2: blk_years = 14'd4;
            default: blk_years = 14'd1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gda_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
        res_reg <= res_next;
        s_reg <= s_next; y_reg <= y_next; m_reg <= m_next;
        c_reg <= c_next; lv_reg <= lv_next;
        sa_reg <= sa_next; k_reg <= k_next;
    end

    always_comb begin
        logic [4:0] ml;
        state_next = state_reg;
        res_next = res_reg;
        s_next = s_reg; y_next = y_reg; m_next = m_reg;
        c_next = c_reg; lv_next = lv_reg;
        sa_next = sa_reg; k_next = k_reg;
        job_ready = 1'b0;
        res_valid = 1'b0;
        ml = gda_pkg::days_in(m_reg, y_reg);
        unique case (state_reg)
            gda_pkg::B_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    res_next = '0;
                    if (job.invalid) begin
                        res_next.input_invalid = 1'b1;
                        state_next = gda_pkg::B_DONE;
                    end else begin
                        res_next.dates_equal = (job.sa == job.sb);
                        res_next.a_later = (job.sa > job.sb);
                        res_next.day_distance = (job.sa > job.sb) ? job.sa - job.sb
                                                                  : job.sb - job.sa;
                        sa_next = job.sa;
                        k_next = job.k;
                        state_next = gda_pkg::B_SUM;
                    end
                end
            end
            gda_pkg::B_SUM: begin
                s_next = sa_reg + 22'(k_reg);
                y_next = 14'd1; m_next = 4'd1;
                c_next = 2'd0; lv_next = 2'd0;
                if (sa_reg + 22'(k_reg) > gda_pkg::LastSerial) begin
                    res_next.sum_day = 5'd31;
                    res_next.sum_month = 4'd12;
                    res_next.sum_year = 14'(gda_pkg::YearMax);
                    res_next.sum_overflow = 1'b1;
                    state_next = gda_pkg::B_DONE;
                end else begin
                    state_next = gda_pkg::B_YEARS;
                end
            end
            gda_pkg::B_YEARS: begin
                // 100- and 1-year levels take at most three blocks.
                if (s_reg >= blk && !((lv_reg == 2'd1 || lv_reg == 2'd3) && c_reg == 2'd3)) begin
                    s_next = s_reg - blk;
                    y_next = y_reg + blk_years;
                    c_next = c_reg + 2'd1;
                end else if (lv_reg == 2'd3) begin
                    state_next = gda_pkg::B_MONTHS;
                end else begin
                    lv_next = lv_reg + 2'd1;
                    c_next = 2'd0;
                end
            end
            gda_pkg::B_MONTHS: begin
                if (s_reg < 22'(ml) || m_reg >= 4'd12) begin
                    res_next.sum_day = 5'(s_reg + 22'd1);
                    res_next.sum_month = m_reg;
                    res_next.sum_year = y_reg;
                    state_next = gda_pkg::B_DONE;
                end else begin
                    s_next = s_reg - 22'(ml);
                    m_next = m_reg + 4'd1;
                end
            end
            gda_pkg::B_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = gda_pkg::B_IDLE;
                end
            end
            default: state_next = gda_pkg::B_IDLE;
        endcase
    end

    assign res = res_reg;
endmodule

// ===== sv/gregorian_date_arith.sv =====
// Gregorian date arithmetic. Each transfer on s_axis carries dates A and B
// and a day count; one transfer on m_axis returns A advanced by the count
// (saturated at 31/12/9999 with sum_overflow), the equal and later flags and
// the distance in days; an invalid A or B returns only input_invalid. The
// front builds both day serials, one 400/100/4/1 year block per cycle for
// both dates at once, then up to twelve months of A and twelve months of B.
// The back rebuilds the sum date the same way, year blocks and then up to
// twelve months. A two-entry queue between them lets the front take the next
// item while the back still works or waits on m_axis, so the sustained rate
// is set by the slower of the two loops.
module gregorian_date_arith (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_day[4:0], a_month[8:5], a_year[22:9], b_day[27:23], b_month[31:28],
    // b_year[45:32], days_to_add[61:46], zero[63:62]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sum_day[4:0], sum_month[8:5], sum_year[22:9], dates_equal[23],
    // a_later[24], day_distance[46:25], sum_overflow[47], input_invalid[48],
    // zero[55:49]
    output logic [55:0] m_axis_tdata
);
    gda_pkg::item_t item;
    gda_pkg::job_t  fjob, qjob;
    gda_pkg::res_t  res;
    logic fvalid, fready, qvalid, qready;

    assign item = gda_pkg::item_t'(s_axis_tdata[61:0]);

    // Validate and build serials.
    gda_front u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(item),
        .job_valid(fvalid), .job_ready(fready), .job(fjob)
    );

    // Hold classified jobs.
    gda_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fvalid), .wr_ready(fready), .wr_job(fjob),
        .rd_valid(qvalid), .rd_ready(qready), .rd_job(qjob)
    );

    // Compare and rebuild the sum date.
    gda_back u_back (
        .aclk, .aresetn,
        .job_valid(qvalid), .job_ready(qready), .job(qjob),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {7'd0, res.input_invalid, res.sum_overflow, res.day_distance,
                           res.a_later, res.dates_equal, res.sum_year, res.sum_month,
                           res.sum_day};
endmodule

// ===== sv/gda_checker.sv =====
`include "gregorian_date_arith_assert.svh"
module gda_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    `GDA_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `GDA_ASSERT(a_inv, m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[47:0] == 48'd0, "invalid result carries data")
    `GDA_ASSERT(a_flags, m_axis_tvalid |-> !(m_axis_tdata[23] && m_axis_tdata[24]), "equal and later both set")
    `GDA_ASSERT_RST(a_rst, !aresetn |=> !m_axis_tvalid, "result valid after reset")
endmodule

bind gregorian_date_arith gda_checker u_gda_checker (
    .aclk, .aresetn,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
